// ===== hw/rtl/spq_pkg.sv =====
// Shared widths, entry layout, status codes and slot addressing for the
// stable priority queue. No dependencies; every other file but spq_ram imports it.
package spq_pkg;

  // Queue sizing and stored field widths
  localparam int CAPACITY    = 16;
  localparam int HANDLE_BITS = 16;
  localparam int PRIO_BITS   = 16;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // Port field widths
  localparam int OPCODE_W = 1;
  localparam int FIELD_W  = 16;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  // Operation codes
  localparam logic [OPCODE_W-1:0] OP_INSERT = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NULL  = 3'd4;

  // One stored queue entry
  typedef struct packed {
    logic        [HANDLE_BITS-1:0] handle;
    logic        [FIELD_W-1:0]     type_tag;
    logic signed [PRIO_BITS-1:0]   prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Physical slot of a logical position, counted from the ring head
  function automatic logic [IDX_W-1:0] slot_addr(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] offs);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, offs};
    if (sum >= (IDX_W + 1)'(CAPACITY)) begin
      sum = sum - (IDX_W + 1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/spq_in_if.sv =====
// Request channel of the stable priority queue: valid/ready plus the
// operation fields. Depends on spq_pkg for field widths.
interface spq_in_if;
  import spq_pkg::*;

  logic                       valid;
  logic                       ready;
  logic        [OPCODE_W-1:0] opcode;
  logic        [FIELD_W-1:0]  item_handle;
  logic        [FIELD_W-1:0]  item_type;
  logic signed [FIELD_W-1:0]  priority_req;

  modport source (output valid, opcode, item_handle, item_type, priority_req,
                  input ready);
  modport sink   (input valid, opcode, item_handle, item_type, priority_req,
                  output ready);
endinterface

// ===== hw/rtl/spq_out_if.sv =====
// Result channel of the stable priority queue: valid/ready plus status,
// count and the removed entry. Depends on spq_pkg for field widths.
interface spq_out_if;
  import spq_pkg::*;

  logic                       valid;
  logic                       ready;
  logic        [STATUS_W-1:0] status;
  logic        [COUNT_W-1:0]  count;
  logic        [FIELD_W-1:0]  out_handle;
  logic        [FIELD_W-1:0]  out_type;
  logic signed [FIELD_W-1:0]  out_priority;

  modport source (output valid, status, count, out_handle, out_type, out_priority,
                  input ready);
  modport sink   (input valid, status, count, out_handle, out_type, out_priority,
                  output ready);
endinterface

// ===== hw/rtl/spq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read
// data. No dependencies.
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/stable_priority_queue_core.sv =====
// Stable priority queue: up to CAPACITY entries (handle, type, signed
// priority) kept sorted by ascending priority in one RAM used as a ring,
// equal priorities leaving in arrival order. One operation is in work at a
// time; a result waits in an output register while the next item is taken.
// A remove reads the head and then pops it. An insert scans the queue for
// a duplicate handle, one entry per read, then walks from the tail
// shifting larger-priority entries up one slot; a duplicate answers where
// it is found and a full queue after the whole scan. Null inserts, empty
// removes and inserts into an empty queue answer from the evaluate state
// without a RAM read. A state that loads a result waits while the output
// register still holds one not taken. The next item can be taken in the
// cycle after its result is loaded. Depends on spq_pkg, spq_in_if,
// spq_out_if and spq_ram.
module stable_priority_queue_core (
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);
  import spq_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_EVAL   = 9'b000000010,
    S_RM_RD  = 9'b000000100,
    S_RM_CHK = 9'b000001000,
    S_SC_RD  = 9'b000010000,
    S_SC_CHK = 9'b000100000,
    S_SH_RD  = 9'b001000000,
    S_SH_CHK = 9'b010000000,
    S_SH_PUT = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // Latched operation
  logic [OPCODE_W-1:0] op_r;
  entry_t              new_r;

  // RAM port
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;

  // Result register
  logic                out_valid_r;
  logic [STATUS_W-1:0] res_status_r;
  logic [COUNT_W-1:0]  res_count_r;
  entry_t              res_entry_r;

  logic                res_load;
  logic [STATUS_W-1:0] res_status;
  entry_t              res_entry;
  logic                out_free;
  logic                last_idx;

  spq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign last_idx    = (CNT_W'(idx_r) == count_r - CNT_W'(1));

  // Sequence one operation: evaluate, remove or scan and shift, report
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    head_nxt   = head_r;
    idx_nxt    = idx_r;
    ram_we     = 1'b0;
    ram_waddr  = slot_addr(head_r, idx_r);
    ram_wdata  = new_r;
    ram_re     = 1'b0;
    ram_raddr  = slot_addr(head_r, idx_r);
    res_load   = 1'b0;
    res_status = ST_OK;
    res_entry  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_EVAL;
        end
      end

      S_EVAL: begin
        if (op_r == OP_REMOVE) begin
          if (count_r == '0) begin
            if (out_free) begin
              res_load   = 1'b1;
              res_status = ST_EMPTY;
              state_nxt  = S_IDLE;
            end
          end else begin
            idx_nxt   = '0;
            state_nxt = S_RM_RD;
          end
        end else if (new_r.handle == '0) begin
          if (out_free) begin
            res_load   = 1'b1;
            res_status = ST_NULL;
            state_nxt  = S_IDLE;
          end
        end else if (count_r == '0) begin
          // Empty queue: place the entry at the head directly
          if (out_free) begin
            ram_we     = 1'b1;
            ram_waddr  = head_r;
            count_nxt  = CNT_W'(1);
            res_load   = 1'b1;
            res_status = ST_OK;
            state_nxt  = S_IDLE;
          end
        end else begin
          idx_nxt   = '0;
          state_nxt = S_SC_RD;
        end
      end

      S_RM_RD: begin
        ram_re    = 1'b1;
        ram_raddr = head_r;
        state_nxt = S_RM_CHK;
      end

      S_RM_CHK: begin
        // Pop the head: advance the ring start
        if (out_free) begin
          res_load   = 1'b1;
          res_status = ST_OK;
          res_entry  = ram_rdata;
          head_nxt   = slot_addr(head_r, IDX_W'(1));
          count_nxt  = count_r - CNT_W'(1);
          state_nxt  = S_IDLE;
        end
      end

      S_SC_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_SC_CHK;
      end

      S_SC_CHK: begin
        if (ram_rdata.handle == new_r.handle) begin
          if (out_free) begin
            res_load   = 1'b1;
            res_status = ST_DUP;
            state_nxt  = S_IDLE;
          end
        end else if (last_idx) begin
          if (count_r == CNT_W'(CAPACITY)) begin
            if (out_free) begin
              res_load   = 1'b1;
              res_status = ST_FULL;
              state_nxt  = S_IDLE;
            end
          end else begin
            // Start the insertion walk at the tail
            idx_nxt   = IDX_W'(count_r - CNT_W'(1));
            state_nxt = S_SH_RD;
          end
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_SC_RD;
        end
      end

      S_SH_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_SH_CHK;
      end

      S_SH_CHK: begin
        ram_waddr = slot_addr(head_r, idx_r + IDX_W'(1));
        if (ram_rdata.prio > new_r.prio) begin
          // Move the larger entry up one slot
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          if (idx_r == '0) begin
            state_nxt = S_SH_PUT;
          end else begin
            idx_nxt   = idx_r - IDX_W'(1);
            state_nxt = S_SH_RD;
          end
        end else if (out_free) begin
          // Drop the new entry behind every smaller or equal priority
          ram_we     = 1'b1;
          count_nxt  = count_r + CNT_W'(1);
          res_load   = 1'b1;
          res_status = ST_OK;
          state_nxt  = S_IDLE;
        end
      end

      S_SH_PUT: begin
        if (out_free) begin
          ram_we     = 1'b1;
          ram_waddr  = head_r;
          count_nxt  = count_r + CNT_W'(1);
          res_load   = 1'b1;
          res_status = ST_OK;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      head_r  <= head_nxt;
      idx_r   <= idx_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the item and hold the result payload
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r            <= in_ch.opcode;
      new_r.handle    <= HANDLE_BITS'(in_ch.item_handle);
      new_r.type_tag  <= in_ch.item_type;
      new_r.prio      <= PRIO_BITS'(in_ch.priority_req);
    end
    if (res_load) begin
      res_status_r <= res_status;
      res_count_r  <= COUNT_W'(count_nxt);
      res_entry_r  <= res_entry;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = res_status_r;
  assign out_ch.count        = res_count_r;
  assign out_ch.out_handle   = FIELD_W'(res_entry_r.handle);
  assign out_ch.out_type     = res_entry_r.type_tag;
  assign out_ch.out_priority = FIELD_W'(res_entry_r.prio);

`ifndef SYNTH
  // Occupancy never exceeds the ring size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("queue count above capacity");

  // A full rejection is only reported with every slot in use
  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && res_status == ST_FULL) |-> count_r == CNT_W'(CAPACITY))
    else $error("full status with free slots");

  // The RAM is never read and written in one cycle
  a_ram_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("RAM read and write overlap");

  // A successful remove shrinks the queue by exactly one
  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && state_r == S_RM_CHK) |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("remove did not decrement count");

  // A new result never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten");
`endif

endmodule

// ===== tb/spq_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the stable priority queue: keeps its own sorted copy of
// the queue, predicts one result per accepted request item and compares.
// Depends on spq_pkg, spq_in_if and spq_out_if.
module spq_result_checker (
  input  logic clk,
  input  logic rst_n,
  spq_in_if    in_mon,
  spq_out_if   out_mon,
  output int   fail_count,
  output int   pending_count,
  output int   checked_count,
  output int   status_seen [5]
);
  import spq_pkg::*;

  typedef struct packed {
    logic        [STATUS_W-1:0] status;
    logic        [COUNT_W-1:0]  count;
    logic        [FIELD_W-1:0]  handle;
    logic        [FIELD_W-1:0]  type_tag;
    logic signed [FIELD_W-1:0]  prio;
  } result_t;

  entry_t  held [CAPACITY];
  int      held_n;
  result_t expected_results [$];
  int      errs;
  int      n_checked;
  int      seen [5];

  // Apply one operation to the shadow queue and build the result it gives
  task automatic queue_apply(input logic [OPCODE_W-1:0] op,
                             input logic [FIELD_W-1:0] h,
                             input logic [FIELD_W-1:0] t,
                             input logic signed [FIELD_W-1:0] p,
                             output result_t r);
    logic [HANDLE_BITS-1:0]      hk;
    logic signed [PRIO_BITS-1:0] pk;
    int                          pos;
    int                          i;
    bit                          dup;
    hk = HANDLE_BITS'(h);
    pk = PRIO_BITS'(p);
    r = '0;
    if (op == OP_INSERT) begin
      dup = 1'b0;
      for (i = 0; i < held_n; i++) begin
        if (held[i].handle == hk) dup = 1'b1;
      end
      // null beats duplicate, duplicate beats full
      if (hk == '0) begin
        r.status = ST_NULL;
      end else if (dup) begin
        r.status = ST_DUP;
      end else if (held_n >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        r.status = ST_OK;
        // land behind every entry of smaller or equal priority, so ties stay FIFO
        pos = 0;
        while (pos < held_n && held[pos].prio <= pk) pos++;
        for (i = held_n; i > pos; i--) held[i] = held[i-1];
        held[pos].handle   = hk;
        held[pos].type_tag = FIELD_W'(t);
        held[pos].prio     = pk;
        held_n++;
      end
    end else if (held_n == 0) begin
      r.status = ST_EMPTY;
    end else begin
      // take the head and close the gap
      r.status   = ST_OK;
      r.handle   = FIELD_W'(held[0].handle);
      r.type_tag = held[0].type_tag;
      r.prio     = FIELD_W'(held[0].prio);
      for (i = 1; i < held_n; i++) held[i-1] = held[i];
      held_n--;
    end
    r.count = COUNT_W'(held_n);
  endtask

  // Predict on accepted requests, compare on accepted results
  always @(posedge clk) begin
    result_t predicted;
    result_t want;
    result_t got;
    if (!rst_n) begin
      held_n = 0;
      expected_results.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        queue_apply(in_mon.opcode, in_mon.item_handle, in_mon.item_type,
                    in_mon.priority_req, predicted);
        expected_results.push_back(predicted);
        seen[predicted.status]++;
      end
      if (out_mon.valid && out_mon.ready) begin
        got.status   = out_mon.status;
        got.count    = out_mon.count;
        got.handle   = out_mon.out_handle;
        got.type_tag = out_mon.out_type;
        got.prio     = out_mon.out_priority;
        n_checked++;
        if (expected_results.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("checker: unexpected result: status %0d count %0d handle %h",
                     got.status, got.count, got.handle);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            errs++;
            if (errs <= 10)
              $display({"checker: result %0d mismatch (exp/got): status %0d/%0d ",
                        "count %0d/%0d handle %h/%h type %h/%h prio %0d/%0d"},
                       n_checked, want.status, got.status, want.count, got.count,
                       want.handle, got.handle, want.type_tag, got.type_tag,
                       want.prio, got.prio);
          end
        end
      end
    end
    fail_count    <= errs;
    pending_count <= expected_results.size();
    checked_count <= n_checked;
    status_seen   <= seen;
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the stable priority queue testbench: clock, reset, request and
// result drivers, watchdog and verdict. Depends on spq_pkg, the channel
// interfaces, stable_priority_queue_core and spq_result_checker.
module testbench;
  import spq_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 500;

  logic clk = 1'b0;
  logic rst_n;
  logic idle_on;
  int   items_sent;
  int   stall_cycles;
  int   fail_count;
  int   pending_count;
  int   checked_count;
  int   status_seen [5];

  spq_in_if  in_bus ();
  spq_out_if out_bus ();

  stable_priority_queue_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  spq_result_checker result_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_bus),
    .out_mon       (out_bus),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count),
    .status_seen   (status_seen)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: drop ready now and then
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready <= !(idle_on && $urandom_range(0, 99) < 11);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Drive one request item and hold it until accepted; starts and ends at a falling edge
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [FIELD_W-1:0] h,
                           input logic [FIELD_W-1:0] t, input logic [FIELD_W-1:0] p);
    if (idle_on && $urandom_range(0, 99) < 11) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_bus.opcode       <= op;
    in_bus.item_handle  <= h;
    in_bus.item_type    <= t;
    in_bus.priority_req <= p;
    in_bus.valid        <= 1'b1;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Random request: handles from a small pool to hit duplicates, priorities
  // clustered half the time to hit ties
  task automatic send_random(input int insert_pct);
    logic [OPCODE_W-1:0] op;
    logic [FIELD_W-1:0]  h;
    logic [FIELD_W-1:0]  t;
    logic [FIELD_W-1:0]  p;
    int                  pick;
    op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      h = '0;
    end else if (pick < 80) begin
      h = FIELD_W'($urandom_range(1, 24));
    end else begin
      h = FIELD_W'($urandom);
    end
    t = FIELD_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      p = FIELD_W'(int'($urandom_range(0, 6)) - 3);
    end else if (pick < 65) begin
      case ($urandom_range(0, 3))
        0: p = 16'h8000;
        1: p = 16'h7FFF;
        2: p = 16'h8001;
        default: p = 16'h7FFE;
      endcase
    end else begin
      p = FIELD_W'($urandom);
    end
    send_item(op, h, t, p);
  endtask

  initial begin
    rst_n               = 1'b0;
    idle_on             = 1'b1;
    in_bus.valid        = 1'b0;
    in_bus.opcode       = OP_INSERT;
    in_bus.item_handle  = '0;
    in_bus.item_type    = '0;
    in_bus.priority_req = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty remove, null handle, ties behind a sole entry
    send_item(OP_REMOVE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(OP_INSERT, 16'h0000, 16'hFFFF, 16'h7FFF);
    send_item(OP_INSERT, 16'd7, 16'h0001, 16'd0);
    send_item(OP_INSERT, 16'd9, 16'h0002, 16'd0);
    send_item(OP_REMOVE, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_INSERT, 16'd11, 16'h0003, 16'd0);
    send_item(OP_REMOVE, 16'h0000, 16'h0000, 16'h0000);
    // Duplicate, then field extremes
    send_item(OP_INSERT, 16'd11, 16'h1234, 16'h8000);
    send_item(OP_INSERT, 16'hFFFF, 16'hFFFF, 16'h8000);
    send_item(OP_INSERT, 16'h0001, 16'h0000, 16'h7FFF);
    // Fill up, then full, duplicate while full, null while full
    for (int i = 0; i < 13; i++) begin
      send_item(OP_INSERT, FIELD_W'(16'h0100 + i), FIELD_W'($urandom),
                FIELD_W'(int'($urandom_range(0, 4)) - 2));
    end
    send_item(OP_INSERT, 16'h0200, 16'h5555, 16'd0);
    send_item(OP_INSERT, 16'h0001, 16'hAAAA, 16'd0);
    send_item(OP_INSERT, 16'h0000, 16'h0000, 16'h8000);

    // Random: insert-heavy, remove-heavy, balanced without idling, balanced
    repeat (PHASE_ITEMS) send_random(75);
    repeat (PHASE_ITEMS) send_random(30);
    idle_on <= 1'b0;
    repeat (PHASE_ITEMS) send_random(50);
    idle_on <= 1'b1;
    repeat (PHASE_ITEMS) send_random(50);
    in_bus.valid <= 1'b0;

    // Drain and let the block settle
    while (pending_count != 0) @(negedge clk);
    repeat (100) @(negedge clk);

    $display("testbench: %0d request items sent, %0d results compared",
             items_sent, checked_count);
    $display("testbench: ok %0d, empty %0d, duplicate %0d, full %0d, null handle %0d",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_DUP],
             status_seen[ST_FULL], status_seen[ST_NULL]);
    if (fail_count == 0 && pending_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== stable_priority_queue_core.f =====
hw/rtl/spq_pkg.sv
hw/rtl/spq_in_if.sv
hw/rtl/spq_out_if.sv
hw/rtl/spq_ram.sv
hw/rtl/stable_priority_queue_core.sv
tb/spq_result_checker.sv
tb/testbench.sv
